[hw/rtl/tsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, character codes and helpers for the timestamp text parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [4:0] BODY_LEN = 5'd19;

   localparam logic [13:0] YEAR_MIN   = 14'd2020;
   localparam logic [13:0] YEAR_MAX   = 14'd2099;
   localparam logic [6:0]  MONTH_MAX  = 7'd12;
   localparam logic [6:0]  HOUR_MAX   = 7'd23;
   localparam logic [6:0]  MINSEC_MAX = 7'd59;

   // fields of a finished text, handed from scanner to checker
   typedef struct packed {
      logic        failed;
      logic        in_tail;
      logic [13:0] year_acc;
      logic [6:0]  month_acc;
      logic [6:0]  day_acc;
      logic [6:0]  hour_acc;
      logic [6:0]  minute_acc;
      logic [6:0]  second_acc;
   } snap_type;

   function automatic logic [13:0] add_digit14(input logic [13:0] acc, input logic [3:0] d);
      add_digit14 = (acc << 3) + (acc << 1) + {10'd0, d};
   endfunction

   function automatic logic [6:0] add_digit7(input logic [6:0] acc, input logic [3:0] d);
      add_digit7 = (acc << 3) + (acc << 1) + {3'd0, d};
   endfunction

   // only meaningful for month 1..12; any other month gives 31
   function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         7'd2: begin
            len = leap ? 5'd29 : 5'd28;
         end
         7'd4, 7'd6, 7'd9, 7'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      month_days = len;
   endfunction

endpackage

[hw/rtl/timestamp_text_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_text_parser
// Streaming parser for "YYYY-MM-DD HH:MM:SS" text, one character per transfer.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless the input stalls. The snapshot
// is taken at the last character's transfer edge; the result register loads
// from it once the result register is empty or its result is taken.
// Input stalls only while a finished snapshot waits behind a held result.
// Synchronous active-high reset returns the scanner to skipping leading spaces
// and empties both registers.
module timestamp_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // final_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [11:0] year, [15:12] month, [20:16] day,
                                    // [25:21] hour, [31:26] minute, [37:32] second
   output logic        rsp_tuser    // valid_res
);

   logic              char_take;
   logic              snap_valid;
   logic              snap_take;
   tsp_pkg::snap_type snap;
   logic [37:0]       rsp_fields;

   assign req_tready = !snap_valid || snap_take;
   assign char_take  = req_tvalid && req_tready;

   tsp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .char_take  (char_take),
      .char_code  (req_tdata),
      .final_char (req_tlast),
      .snap_take  (snap_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   tsp_check u_check (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_ok     (rsp_tuser),
      .rsp_fields (rsp_fields)
   );

   assign rsp_tdata = {2'b00, rsp_fields};

endmodule

[hw/rtl/tsp_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_scan
// Per-character scanner: skips leading spaces, checks the body layout,
// accumulates the digit fields and latches a snapshot on the last character.
// ----------------------------------------------------------------------------
module tsp_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              char_take,
   input  logic [7:0]        char_code,
   input  logic              final_char,
   input  logic              snap_take,
   output logic              snap_valid,
   output tsp_pkg::snap_type snap
);

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_TAIL = 2'd2;

   localparam logic [4:0] POS_DASH_A  = 5'd4;
   localparam logic [4:0] POS_DASH_B  = 5'd7;
   localparam logic [4:0] POS_SPACE   = 5'd10;
   localparam logic [4:0] POS_COLON_A = 5'd13;
   localparam logic [4:0] POS_COLON_B = 5'd16;
   localparam logic [4:0] POS_YEAR_END   = 5'd3;
   localparam logic [4:0] POS_MONTH_END  = 5'd6;
   localparam logic [4:0] POS_DAY_END    = 5'd9;
   localparam logic [4:0] POS_HOUR_END   = 5'd12;
   localparam logic [4:0] POS_MINUTE_END = 5'd15;

   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  position_ff, position_in;
   logic        failed_ff, failed_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        snap_valid_ff, snap_valid_in;
   tsp_pkg::snap_type snap_ff, snap_in;

   logic       body;
   logic [4:0] pos_cur;
   logic [4:0] pos_next;
   logic       is_digit;
   logic       is_ws;
   logic [7:0] digit_wide;
   logic [3:0] digit;

   assign digit_wide = char_code - tsp_pkg::CHAR_ZERO;
   assign digit      = digit_wide[3:0];
   assign is_digit   = (char_code >= tsp_pkg::CHAR_ZERO) && (char_code <= tsp_pkg::CHAR_NINE);
   assign is_ws      = (char_code == tsp_pkg::CHAR_SPACE) || (char_code == tsp_pkg::CHAR_TAB) ||
                       (char_code == tsp_pkg::CHAR_CR) || (char_code == tsp_pkg::CHAR_LF);
   assign pos_cur    = (phase_ff == PH_SKIP) ? 5'd0 : position_ff;
   assign pos_next   = pos_cur + 5'd1;

   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      failed_in   = failed_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      body        = 1'b0;

      if (phase_ff == PH_SKIP) begin
         if (char_code != tsp_pkg::CHAR_SPACE) begin
            body = 1'b1;
         end
      end else if (phase_ff == PH_BODY) begin
         body = 1'b1;
      end else if (!is_ws) begin
         failed_in = 1'b1;
      end

      if (body) begin
         if (pos_cur == POS_DASH_A || pos_cur == POS_DASH_B) begin
            if (char_code != tsp_pkg::CHAR_DASH) failed_in = 1'b1;
         end else if (pos_cur == POS_SPACE) begin
            if (char_code != tsp_pkg::CHAR_SPACE) failed_in = 1'b1;
         end else if (pos_cur == POS_COLON_A || pos_cur == POS_COLON_B) begin
            if (char_code != tsp_pkg::CHAR_COLON) failed_in = 1'b1;
         end else if (!is_digit) begin
            failed_in = 1'b1;
         end else if (pos_cur <= POS_YEAR_END) begin
            year_in = tsp_pkg::add_digit14(year_ff, digit);
         end else if (pos_cur <= POS_MONTH_END) begin
            month_in = tsp_pkg::add_digit7(month_ff, digit);
         end else if (pos_cur <= POS_DAY_END) begin
            day_in = tsp_pkg::add_digit7(day_ff, digit);
         end else if (pos_cur <= POS_HOUR_END) begin
            hour_in = tsp_pkg::add_digit7(hour_ff, digit);
         end else if (pos_cur <= POS_MINUTE_END) begin
            minute_in = tsp_pkg::add_digit7(minute_ff, digit);
         end else begin
            second_in = tsp_pkg::add_digit7(second_ff, digit);
         end
         position_in = pos_next;
         phase_in    = (pos_next >= tsp_pkg::BODY_LEN) ? PH_TAIL : PH_BODY;
      end
   end

   always_comb begin
      snap_in.failed     = failed_in;
      snap_in.in_tail    = (phase_in == PH_TAIL);
      snap_in.year_acc   = year_in;
      snap_in.month_acc  = month_in;
      snap_in.day_acc    = day_in;
      snap_in.hour_acc   = hour_in;
      snap_in.minute_acc = minute_in;
      snap_in.second_acc = second_in;
      if (char_take && final_char) begin
         snap_valid_in = 1'b1;
      end else if (snap_take) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP;
         position_ff   <= 5'd0;
         failed_ff     <= 1'b0;
         year_ff       <= 14'd0;
         month_ff      <= 7'd0;
         day_ff        <= 7'd0;
         hour_ff       <= 7'd0;
         minute_ff     <= 7'd0;
         second_ff     <= 7'd0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (char_take) begin
            if (final_char) begin
               phase_ff    <= PH_SKIP;
               position_ff <= 5'd0;
               failed_ff   <= 1'b0;
               year_ff     <= 14'd0;
               month_ff    <= 7'd0;
               day_ff      <= 7'd0;
               hour_ff     <= 7'd0;
               minute_ff   <= 7'd0;
               second_ff   <= 7'd0;
            end else begin
               phase_ff    <= phase_in;
               position_ff <= position_in;
               failed_ff   <= failed_in;
               year_ff     <= year_in;
               month_ff    <= month_in;
               day_ff      <= day_in;
               hour_ff     <= hour_in;
               minute_ff   <= minute_in;
               second_ff   <= second_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (char_take && final_char) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

[hw/rtl/tsp_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_check
// Range and calendar checks on a finished text, with the result register.
// ----------------------------------------------------------------------------
module tsp_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   input  tsp_pkg::snap_type snap,
   output logic              snap_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic [37:0]       rsp_fields
);

   logic        out_valid_ff, out_valid_in;
   logic        ok_ff, ok_in;
   logic [37:0] fields_ff, fields_in;
   logic [4:0]  mlen;
   logic        leap;

   assign snap_take = !out_valid_ff || rsp_ready;
   assign leap      = (snap.year_acc[1:0] == 2'b00);
   assign mlen      = tsp_pkg::month_days(snap.month_acc, leap);

   always_comb begin
      ok_in = !snap.failed && snap.in_tail &&
              (snap.year_acc >= tsp_pkg::YEAR_MIN) && (snap.year_acc <= tsp_pkg::YEAR_MAX) &&
              (snap.month_acc >= 7'd1) && (snap.month_acc <= tsp_pkg::MONTH_MAX) &&
              (snap.hour_acc <= tsp_pkg::HOUR_MAX) &&
              (snap.minute_acc <= tsp_pkg::MINSEC_MAX) &&
              (snap.second_acc <= tsp_pkg::MINSEC_MAX) &&
              (snap.day_acc >= 7'd1) && (snap.day_acc <= {2'b00, mlen});
      if (ok_in) begin
         fields_in = {snap.second_acc[5:0], snap.minute_acc[5:0], snap.hour_acc[4:0],
                      snap.day_acc[4:0], snap.month_acc[3:0], snap.year_acc[11:0]};
      end else begin
         fields_in = 38'd0;
      end
      if (snap_valid && snap_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_take) begin
         ok_ff     <= ok_in;
         fields_ff <= fields_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_fields = fields_ff;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamp texts one character per transfer into the parser, with
// random gaps and back-pressure. Each result is checked against a scanner
// kept in the bench that tracks the same text state per accepted character.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int END_CYCLES   = 20;
   localparam int RANDOM_CHARS = 1650;

   localparam logic [1:0] SCAN_SKIP = 2'd0;
   localparam logic [1:0] SCAN_BODY = 2'd1;
   localparam logic [1:0] SCAN_TAIL = 2'd2;

   typedef struct packed {
      logic [7:0] code;
      logic       is_last;
   } char_xfer_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } stamp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   char_xfer_type char_queue[$];
   logic [7:0]    text_buf[$];
   stamp_type     stamp_expected[$];

   int unsigned chars_sent   = 0;
   int unsigned chars_taken  = 0;
   int unsigned req_gap      = 0;
   int unsigned stamps_seen  = 0;
   int unsigned stamps_noted = 0;
   int unsigned rsp_stall    = 0;
   int unsigned cycle_count  = 0;
   int unsigned error_count  = 0;

   logic [1:0]  scan_phase;
   logic [4:0]  scan_pos;
   logic        scan_bad;
   logic [13:0] acc_year;
   logic [6:0]  acc_month;
   logic [6:0]  acc_day;
   logic [6:0]  acc_hour;
   logic [6:0]  acc_minute;
   logic [6:0]  acc_second;

   timestamp_text_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int month_length(input int y, input int m);
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2: begin
            return leap ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // quiet windows give stretches with no idling on either side
   function automatic int unsigned draw_gap();
      if ((cycle_count % 5000) < 1000) return 0;
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 16);
      return 0;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: begin
            return tsp_pkg::CHAR_SPACE;
         end
         1: begin
            return tsp_pkg::CHAR_TAB;
         end
         2: begin
            return tsp_pkg::CHAR_CR;
         end
         default: begin
            return tsp_pkg::CHAR_LF;
         end
      endcase
   endfunction

   task automatic clear_scan();
      scan_phase = SCAN_SKIP;
      scan_pos   = '0;
      scan_bad   = 1'b0;
      acc_year   = '0;
      acc_month  = '0;
      acc_day    = '0;
      acc_hour   = '0;
      acc_minute = '0;
      acc_second = '0;
   endtask

   task automatic take_body(input logic [7:0] ch);
      logic [3:0] d;
      d = ch[3:0];
      if (scan_pos == 4 || scan_pos == 7) begin
         if (ch != tsp_pkg::CHAR_DASH) scan_bad = 1'b1;
      end else if (scan_pos == 10) begin
         if (ch != tsp_pkg::CHAR_SPACE) scan_bad = 1'b1;
      end else if (scan_pos == 13 || scan_pos == 16) begin
         if (ch != tsp_pkg::CHAR_COLON) scan_bad = 1'b1;
      end else if (ch < tsp_pkg::CHAR_ZERO || ch > tsp_pkg::CHAR_NINE) begin
         scan_bad = 1'b1;
      end else if (scan_pos <= 3) begin
         acc_year = acc_year * 14'd10 + {10'd0, d};
      end else if (scan_pos <= 6) begin
         acc_month = acc_month * 7'd10 + {3'd0, d};
      end else if (scan_pos <= 9) begin
         acc_day = acc_day * 7'd10 + {3'd0, d};
      end else if (scan_pos <= 12) begin
         acc_hour = acc_hour * 7'd10 + {3'd0, d};
      end else if (scan_pos <= 15) begin
         acc_minute = acc_minute * 7'd10 + {3'd0, d};
      end else begin
         acc_second = acc_second * 7'd10 + {3'd0, d};
      end
      scan_pos = scan_pos + 5'd1;
      if (scan_pos >= tsp_pkg::BODY_LEN) scan_phase = SCAN_TAIL;
   endtask

   task automatic scan_char(input logic [7:0] ch, input logic fin,
                            output logic produced, output stamp_type res);
      logic ok;
      produced = 1'b0;
      res      = '0;
      if (scan_phase == SCAN_SKIP) begin
         if (ch != tsp_pkg::CHAR_SPACE) begin
            scan_phase = SCAN_BODY;
            scan_pos   = '0;
            take_body(ch);
         end
      end else if (scan_phase == SCAN_BODY) begin
         take_body(ch);
      end else if (ch != tsp_pkg::CHAR_SPACE && ch != tsp_pkg::CHAR_TAB &&
                   ch != tsp_pkg::CHAR_CR && ch != tsp_pkg::CHAR_LF) begin
         scan_bad = 1'b1;
      end
      if (fin) begin
         ok = !scan_bad && scan_phase == SCAN_TAIL &&
              acc_year >= tsp_pkg::YEAR_MIN && acc_year <= tsp_pkg::YEAR_MAX &&
              acc_month >= 1 && acc_month <= tsp_pkg::MONTH_MAX &&
              acc_hour <= tsp_pkg::HOUR_MAX && acc_minute <= tsp_pkg::MINSEC_MAX &&
              acc_second <= tsp_pkg::MINSEC_MAX && acc_day >= 1;
         if (ok && acc_day > month_length(acc_year, acc_month)) ok = 1'b0;
         if (ok) begin
            res = '{1'b1, acc_year[11:0], acc_month[3:0], acc_day[4:0],
                    acc_hour[4:0], acc_minute[5:0], acc_second[5:0]};
         end
         produced = 1'b1;
         clear_scan();
      end
   endtask

   task automatic note_error(input string what, input stamp_type want, input stamp_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   task automatic flush_text();
      char_xfer_type x;
      for (int i = 0; i < text_buf.size(); i++) begin
         x.code    = text_buf[i];
         x.is_last = (i == text_buf.size() - 1);
         char_queue.push_back(x);
      end
      text_buf.delete();
   endtask

   task automatic put_digits(input int v, input int n);
      int p;
      p = 1;
      for (int i = 1; i < n; i++) p = p * 10;
      for (int i = 0; i < n; i++) begin
         text_buf.push_back(tsp_pkg::CHAR_ZERO + 8'((v / p) % 10));
         p = p / 10;
      end
   endtask

   task automatic put_stamp(input int y, input int mo, input int d,
                            input int h, input int mi, input int s);
      put_digits(y, 4);
      text_buf.push_back(tsp_pkg::CHAR_DASH);
      put_digits(mo, 2);
      text_buf.push_back(tsp_pkg::CHAR_DASH);
      put_digits(d, 2);
      text_buf.push_back(tsp_pkg::CHAR_SPACE);
      put_digits(h, 2);
      text_buf.push_back(tsp_pkg::CHAR_COLON);
      put_digits(mi, 2);
      text_buf.push_back(tsp_pkg::CHAR_COLON);
      put_digits(s, 2);
   endtask

   task automatic make_random_text();
      int kind, y, mo, d, h, mi, s, n, p;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) text_buf.push_back(tsp_pkg::CHAR_SPACE);
         end
         case ($urandom_range(0, 5))
            0: y = 2020;
            1: y = 2099;
            2: y = $urandom_range(2000, 2120);
            3: y = $urandom_range(0, 9999);
            default: y = $urandom_range(2020, 2099);
         endcase
         case ($urandom_range(0, 9))
            0: mo = $urandom_range(0, 99);
            1: mo = $urandom_range(0, 1) ? 1 : 12;
            default: mo = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0: d = $urandom_range(0, 99);
            1, 2: d = month_length(y, mo) + $urandom_range(0, 1);
            3: d = $urandom_range(0, 1);
            default: d = $urandom_range(1, month_length(y, mo));
         endcase
         case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 99);
            1: h = $urandom_range(23, 24);
            default: h = $urandom_range(0, 23);
         endcase
         case ($urandom_range(0, 9))
            0: mi = $urandom_range(0, 99);
            1: mi = $urandom_range(59, 60);
            default: mi = $urandom_range(0, 59);
         endcase
         case ($urandom_range(0, 9))
            0: s = $urandom_range(0, 99);
            1: s = $urandom_range(59, 60);
            default: s = $urandom_range(0, 59);
         endcase
         put_stamp(y, mo, d, h, mi, s);
         n = $urandom_range(0, 3);
         repeat (n) text_buf.push_back(blank_char());
         if (kind >= 65) begin
            case ($urandom_range(0, 3))
               0: begin
                  p = $urandom_range(0, text_buf.size() - 1);
                  text_buf[p] = 8'($urandom_range(0, 255));
               end
               1: begin
                  n = $urandom_range(1, text_buf.size() - 1);
                  while (text_buf.size() > n) void'(text_buf.pop_back());
               end
               2: begin
                  text_buf.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  text_buf.push_front(tsp_pkg::CHAR_TAB);
               end
            endcase
         end
      end else begin
         n = $urandom_range(1, 30);
         repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      flush_text();
   endtask

   // character source
   always @(negedge clock) begin : drive_chars
      char_xfer_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && chars_sent != chars_taken) begin
         // transfer still pending
      end else if (req_gap != 0) begin
         req_tvalid <= 1'b0;
         req_gap    <= req_gap - 1;
      end else if (char_queue.size() != 0) begin
         nxt = char_queue.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= nxt.code;
         req_tlast  <= nxt.is_last;
         chars_sent <= chars_sent + 1;
         req_gap    <= draw_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin : pace_results
      int unsigned g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stamps_seen != stamps_noted) begin
         g = draw_gap();
         stamps_noted <= stamps_seen;
         rsp_tready   <= (g == 0);
         rsp_stall    <= (g == 0) ? 0 : g - 1;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch
      logic      produced;
      stamp_type made, want, got;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            chars_taken <= chars_taken + 1;
            scan_char(req_tdata, req_tlast, produced, made);
            if (produced) stamp_expected.push_back(made);
         end
         if (rsp_tvalid && rsp_tready) begin
            stamps_seen <= stamps_seen + 1;
            got = '{rsp_tuser, rsp_tdata[11:0], rsp_tdata[15:12], rsp_tdata[20:16],
                    rsp_tdata[25:21], rsp_tdata[31:26], rsp_tdata[37:32]};
            if (stamp_expected.size() == 0) begin
               note_error("unexpected result", '0, got);
            end else begin
               want = stamp_expected.pop_front();
               if (got !== want) note_error("result mismatch", want, got);
            end
         end
      end
   end

   initial begin
      clear_scan();

      // leap day with a trailing CR
      put_stamp(2024, 2, 29, 23, 59, 59);
      text_buf.push_back(tsp_pkg::CHAR_CR);
      flush_text();
      // text ends while still skipping spaces
      text_buf.push_back(tsp_pkg::CHAR_SPACE);
      flush_text();
      // tab is not skipped, it opens the body
      text_buf.push_back(tsp_pkg::CHAR_TAB);
      text_buf.push_back(tsp_pkg::CHAR_ZERO);
      flush_text();
      text_buf.push_back(8'hFF);
      flush_text();

      n_loop: while (char_queue.size() < RANDOM_CHARS + 24) make_random_text();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || chars_sent != chars_taken ||
             stamp_expected.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[timestamp_text_parser.f]
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_scan.sv
hw/rtl/tsp_check.sv
hw/rtl/timestamp_text_parser.sv
verif/testbench.sv
